// ===== hdl/nnt_pkg.sv =====
// Shared types, codes and field widths of the nearest-neighbour tour builder.
package nnt_pkg;

  // Fixed widths of the item fields and the configuration port
  localparam int CITY_W     = 6;
  localparam int POS_W      = 6;
  localparam int DIST_IN_W  = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int COUNT_W    = 7;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CITY = 1'b1;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0] CITY_COUNT_RST = 7'd64;
  localparam logic [CITY_W-1:0]  FIRST_CITY_RST = 6'd0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // What the sequencer does once the staged result item has left
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_SCAN,
    AFT_TAIL
  } after_e;

  // Control from the sequencer to the shared compare unit
  typedef struct packed {
    logic clear;
    logic cand_valid;
    logic cand_free;
  } scan_ctrl_t;

endpackage

// ===== hdl/nearest_neighbour_tour_builder.sv =====
// Top level of the nearest-neighbour tour builder: sequencer, marks and result register.
// A write item (func 0) stores one distance. A run item (func 1) builds a
// greedy tour over the first n cities from the configured start: every step scans the
// current row once through the single read port of the distance memory, one entry a
// cycle into one comparator, and ends by loading a result item. Input is not ready
// during a run. The last city of a tour, also one cut short because no reachable
// unvisited city remains, has last_city set.
module nearest_neighbour_tour_builder #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_BITS  = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nnt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nnt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input item channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [nnt_pkg::CITY_W-1:0]       row_city_i,
  input  logic [nnt_pkg::CITY_W-1:0]       col_city_i,
  input  logic [nnt_pkg::DIST_IN_W-1:0]    dist_value_i,
  // result item channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [nnt_pkg::CITY_W-1:0]       tour_city_o,
  output logic [nnt_pkg::POS_W-1:0]        tour_pos_o,
  output logic                             last_city_o
);

  localparam int CW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);

  nnt_pkg::state_e     state_q, state_d;
  nnt_pkg::after_e     after_q;
  nnt_pkg::scan_ctrl_t scan_ctrl;

  logic [nnt_pkg::COUNT_W-1:0] city_count_q;
  logic [nnt_pkg::CITY_W-1:0]  first_city_q;

  logic [MAX_CITIES-1:0] visited_q;
  logic [CW-1:0]         cur_q;
  logic [NW-1:0]         n_q;
  logic [NW-1:0]         pos_q;
  logic [CW-1:0]         j_q;
  logic [CW-1:0]         rd_idx_q;
  logic                  rd_vld_q;
  logic [CW-1:0]         pend_city_q;
  logic [NW-1:0]         pend_pos_q;
  logic [CW-1:0]         emit_city_q;
  logic [NW-1:0]         emit_pos_q;
  logic                  emit_last_q;
  logic                  out_valid_q;
  logic [nnt_pkg::CITY_W-1:0] out_city_q;
  logic [nnt_pkg::POS_W-1:0]  out_pos_q;
  logic                  out_last_q;

  logic                 in_acc;
  logic                 run_acc;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DIST_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [DIST_BITS-1:0] rd_data;
  logic                 found;
  logic [CW-1:0]        best_idx;
  logic [NW-1:0]        n_run;
  logic [CW-1:0]        origin_city;
  logic                 last_issue;
  logic                 out_load;

  // Configuration port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= nnt_pkg::CITY_COUNT_RST;
      first_city_q <= nnt_pkg::FIRST_CITY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nnt_pkg::CFG_CITY_COUNT: city_count_q <= cfg_data_i;
        nnt_pkg::CFG_FIRST_CITY: first_city_q <= nnt_pkg::CITY_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Effective city count and start city of a run
  always_comb begin
    if (32'(city_count_q) > MAX_CITIES) begin
      n_run = NW'(MAX_CITIES);
    end else if (city_count_q == '0) begin
      n_run = NW'(1);
    end else begin
      n_run = NW'(city_count_q);
    end
    origin_city = (32'(first_city_q) < 32'(n_run)) ? CW'(first_city_q) : '0;
  end

  assign in_acc  = in_valid_i && in_ready_o;
  assign run_acc = in_acc && (func_i == nnt_pkg::FUNC_RUN);

  // Distance write path, out-of-range cities dropped
  assign wr_en   = in_acc && (func_i == nnt_pkg::FUNC_WRITE) &&
                   (32'(row_city_i) < MAX_CITIES) && (32'(col_city_i) < MAX_CITIES);
  assign wr_addr = AW'(int'(row_city_i) * MAX_CITIES + int'(col_city_i));
  assign wr_data = DIST_BITS'(dist_value_i);
  assign rd_addr = AW'(int'(cur_q) * MAX_CITIES + int'(j_q));

  nnt_dist_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DIST_BITS),
    .ADDR_W (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nnt_scan #(
    .DIST_BITS (DIST_BITS),
    .IDX_W     (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .cand_dist_i (rd_data),
    .cand_idx_i  (rd_idx_q),
    .found_o     (found),
    .best_idx_o  (best_idx)
  );

  assign last_issue = (NW'(j_q) == (n_q - NW'(1)));

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nnt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and sequencer controls
  always_comb begin
    state_d              = state_q;
    in_ready_o           = 1'b0;
    rd_en                = 1'b0;
    out_load             = 1'b0;
    scan_ctrl.clear      = 1'b0;
    scan_ctrl.cand_valid = rd_vld_q;
    scan_ctrl.cand_free  = !visited_q[rd_idx_q];
    case (state_q)
      nnt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (run_acc) begin
          if (n_run == NW'(1)) begin
            state_d = nnt_pkg::ST_EMIT;
          end else begin
            state_d         = nnt_pkg::ST_SCAN;
            scan_ctrl.clear = 1'b1;
          end
        end
      end
      nnt_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_d = nnt_pkg::ST_WAIT;
        end
      end
      nnt_pkg::ST_WAIT: begin
        state_d = nnt_pkg::ST_DECIDE;
      end
      nnt_pkg::ST_DECIDE: begin
        state_d = nnt_pkg::ST_EMIT;
      end
      nnt_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          case (after_q)
            nnt_pkg::AFT_IDLE: state_d = nnt_pkg::ST_IDLE;
            nnt_pkg::AFT_SCAN: begin
              state_d         = nnt_pkg::ST_SCAN;
              scan_ctrl.clear = 1'b1;
            end
            default: state_d = nnt_pkg::ST_EMIT;
          endcase
        end
      end
      default: state_d = nnt_pkg::ST_IDLE;
    endcase
  end

  // Control registers: marks, current city, staged last flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q   <= '0;
      cur_q       <= '0;
      rd_vld_q    <= 1'b0;
      emit_last_q <= 1'b0;
      after_q     <= nnt_pkg::AFT_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (run_acc) begin
        visited_q   <= {{(MAX_CITIES-1){1'b0}}, 1'b1} << origin_city;
        cur_q       <= origin_city;
        emit_last_q <= 1'b1;
        after_q     <= nnt_pkg::AFT_IDLE;
      end
      if (state_q == nnt_pkg::ST_DECIDE) begin
        if (found) begin
          visited_q[best_idx] <= 1'b1;
          cur_q               <= best_idx;
          emit_last_q         <= 1'b0;
          after_q <= (pos_q == (n_q - NW'(1))) ? nnt_pkg::AFT_TAIL : nnt_pkg::AFT_SCAN;
        end else begin
          emit_last_q <= 1'b1;
          after_q     <= nnt_pkg::AFT_IDLE;
        end
      end
      if (out_load && (after_q == nnt_pkg::AFT_TAIL)) begin
        emit_last_q <= 1'b1;
        after_q     <= nnt_pkg::AFT_IDLE;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: counters, pending city, staged and output items
  always_ff @(posedge clk_i) begin
    if (run_acc) begin
      n_q         <= n_run;
      pos_q       <= NW'(1);
      j_q         <= '0;
      pend_city_q <= origin_city;
      pend_pos_q  <= '0;
      emit_city_q <= origin_city;
      emit_pos_q  <= '0;
    end
    if (rd_en) begin
      j_q      <= j_q + CW'(1);
      rd_idx_q <= j_q;
    end
    if (state_q == nnt_pkg::ST_DECIDE) begin
      emit_city_q <= pend_city_q;
      emit_pos_q  <= pend_pos_q;
      j_q         <= '0;
      if (found) begin
        pend_city_q <= best_idx;
        pend_pos_q  <= pos_q;
        pos_q       <= pos_q + NW'(1);
      end
    end
    if (out_load) begin
      out_city_q <= nnt_pkg::CITY_W'(emit_city_q);
      out_pos_q  <= nnt_pkg::POS_W'(emit_pos_q);
      out_last_q <= emit_last_q;
      if (after_q == nnt_pkg::AFT_TAIL) begin
        emit_city_q <= pend_city_q;
        emit_pos_q  <= pend_pos_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tour_city_o = out_city_q;
  assign tour_pos_o  = out_pos_q;
  assign last_city_o = out_last_q;

  // A city picked by a scan was not already visited
  a_pick_unvisited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nnt_pkg::ST_DECIDE) && found |-> !visited_q[best_idx])
    else $error("picked city already visited");

  // The final item of a tour returns the sequencer to idle
  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && emit_last_q |=> (state_q == nnt_pkg::ST_IDLE))
    else $error("tour continued after final item");

  // An item that is not final keeps the run going
  a_mid_keeps_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !emit_last_q |=> (state_q != nnt_pkg::ST_IDLE))
    else $error("tour ended without final item");

endmodule

// ===== hdl/nnt_dist_mem.sv =====
// Distance matrix storage: one write port, one registered read port.
module nnt_dist_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 24,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Store one distance
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one distance, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/nnt_scan.sv =====
// Shared compare unit: keeps the smallest reachable distance seen in a row scan.
module nnt_scan #(
  parameter int DIST_BITS = 24,
  parameter int IDX_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nnt_pkg::scan_ctrl_t  ctrl_i,
  input  logic [DIST_BITS-1:0] cand_dist_i,
  input  logic [IDX_W-1:0]     cand_idx_i,
  output logic                 found_o,
  output logic [IDX_W-1:0]     best_idx_o
);

  localparam logic [DIST_BITS-1:0] NO_EDGE = '1;

  logic                 found_q;
  logic [DIST_BITS-1:0] best_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 take;

  // Take a candidate only if strictly closer; earlier index wins ties
  assign take = ctrl_i.cand_valid && ctrl_i.cand_free && (cand_dist_i != NO_EDGE) &&
                (!found_q || (cand_dist_i < best_q));

  // Track whether any candidate was taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  // Hold the best distance and its city
  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clear) begin
      best_q <= cand_dist_i;
      idx_q  <= cand_idx_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = idx_q;

endmodule
